// ===== design/epv_pkg.sv =====
// shared constants, types and the quarter-wave sine table builder for the ellipse polygon core
// no dependencies; every other design file uses this package by scoped names
package epv_pkg;

    localparam int MAX_SEGMENTS     = 63;
    localparam int MIN_SEGMENTS     = 8;
    localparam int DEFAULT_SEGMENTS = 32;
    localparam int ANGLE_STEPS      = 4096;
    localparam int QUARTER_STEPS    = ANGLE_STEPS / 4;

    localparam int SEG_W    = 6;
    localparam int COORD_W  = 16;
    localparam int RADIUS_W = 15;
    localparam int TRIG_W   = 16;
    localparam int FRAC_BITS = 15;
    localparam int PROD_W   = RADIUS_W + TRIG_W;
    localparam int ANGLE_W  = $clog2(ANGLE_STEPS);
    localparam int ADIV_W   = $clog2(ANGLE_STEPS + 1);
    localparam int DCNT_W   = $clog2(ADIV_W);
    localparam int ROM_AW   = $clog2(QUARTER_STEPS + 1);

    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;

    typedef logic [TRIG_W-1:0] t_sine_rom [0:QUARTER_STEPS];

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_GEN
    } t_seq_state;

    // one vertex request handed from the sequencer to the datapath
    typedef struct packed {
        logic                valid;
        logic                last;
        logic [ANGLE_W-1:0]  angle;
        logic [COORD_W-1:0]  center_x;
        logic [COORD_W-1:0]  center_y;
        logic [RADIUS_W-1:0] radius_x;
        logic [RADIUS_W-1:0] radius_y;
    } t_issue;

    // sin over the first quadrant, q1.15, by a truncated taylor series in q30
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom       rom;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned e;
        for (int k = 0; k <= QUARTER_STEPS; k++) begin
            x  = (longint'(k) * 64'd2 * PI_Q30) / ANGLE_STEPS;
            x2 = (x * x) >> 30;
            t  = ONE_Q30;
            t  = ONE_Q30 - (((x2 * t) >> 30) / 156);
            t  = ONE_Q30 - (((x2 * t) >> 30) / 110);
            t  = ONE_Q30 - (((x2 * t) >> 30) / 72);
            t  = ONE_Q30 - (((x2 * t) >> 30) / 42);
            t  = ONE_Q30 - (((x2 * t) >> 30) / 20);
            t  = ONE_Q30 - (((x2 * t) >> 30) / 6);
            s  = (x * t) >> 30;
            e  = (s + 64'd16384) >> 15;
            if (e > 64'd32768) begin
                e = 64'd32768;
            end
            rom[k] = e[TRIG_W-1:0];
        end
        return rom;
    endfunction

endpackage

// ===== design/epv_sine_rom.sv =====
// quarter-wave sine rom, two read ports, registered read data
// depends on epv_pkg for the table contents and widths
module epv_sine_rom (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [epv_pkg::ROM_AW-1:0] i_addr_a,
    input  logic [epv_pkg::ROM_AW-1:0] i_addr_b,
    output logic [epv_pkg::TRIG_W-1:0] o_data_a,
    output logic [epv_pkg::TRIG_W-1:0] o_data_b
);

    localparam epv_pkg::t_sine_rom SINE_ROM = epv_pkg::build_sine_rom();

    logic [epv_pkg::TRIG_W-1:0] r_data_a;
    logic [epv_pkg::TRIG_W-1:0] r_data_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data_a <= SINE_ROM[i_addr_a];
            r_data_b <= SINE_ROM[i_addr_b];
        end
    end

    assign o_data_a = r_data_a;
    assign o_data_b = r_data_b;

endmodule

// ===== design/epv_seq.sv =====
// request sequencer: takes a request, divides the circle by the segment count, steps the angles
// depends on epv_pkg for the state enum, the issue struct and the widths
module epv_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [epv_pkg::COORD_W-1:0]  i_center_x,
    input  logic [epv_pkg::COORD_W-1:0]  i_center_y,
    input  logic [epv_pkg::RADIUS_W-1:0] i_radius_x,
    input  logic [epv_pkg::RADIUS_W-1:0] i_radius_y,
    input  logic [epv_pkg::SEG_W-1:0]    i_segment_count,
    input  logic                         i_advance,
    output epv_pkg::t_issue              o_issue
);

    localparam int SEG_W   = epv_pkg::SEG_W;
    localparam int ANGLE_W = epv_pkg::ANGLE_W;
    localparam int ADIV_W  = epv_pkg::ADIV_W;
    localparam int DCNT_W  = epv_pkg::DCNT_W;
    localparam logic [ADIV_W-1:0] DIVIDEND = ADIV_W'(epv_pkg::ANGLE_STEPS);

    epv_pkg::t_seq_state r_state, n_state;

    logic [SEG_W-1:0]            r_seg, n_seg;
    logic [epv_pkg::COORD_W-1:0] r_cx, n_cx, r_cy, n_cy;
    logic [epv_pkg::RADIUS_W-1:0] r_rx, n_rx, r_ry, n_ry;
    logic [SEG_W-1:0]            r_div_rem, n_div_rem;
    logic [ADIV_W-1:0]           r_div_quo, n_div_quo;
    logic [DCNT_W-1:0]           r_div_cnt, n_div_cnt;
    logic [ANGLE_W-1:0]          r_angle, n_angle;
    logic [SEG_W-1:0]            r_frac, n_frac;
    logic [SEG_W-1:0]            r_vtx, n_vtx;

    logic             w_accept;
    logic [SEG_W-1:0] w_eff_seg;
    logic [SEG_W:0]   w_trial;
    logic [SEG_W:0]   w_trial_sub;
    logic             w_fits;
    logic [SEG_W:0]   w_acc;
    logic             w_wrap;
    logic [SEG_W:0]   w_acc_sub;
    logic             w_last;

    assign o_stall  = (r_state != epv_pkg::ST_IDLE);
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        if (i_segment_count < SEG_W'(epv_pkg::MIN_SEGMENTS)) begin
            w_eff_seg = SEG_W'(epv_pkg::DEFAULT_SEGMENTS);
        end else if (i_segment_count > SEG_W'(epv_pkg::MAX_SEGMENTS)) begin
            w_eff_seg = SEG_W'(epv_pkg::MAX_SEGMENTS);
        end else begin
            w_eff_seg = i_segment_count;
        end
    end

    // restoring division, one quotient bit per cycle
    assign w_trial     = {r_div_rem, DIVIDEND[r_div_cnt]};
    assign w_fits      = (w_trial >= {1'b0, r_seg});
    assign w_trial_sub = w_trial - {1'b0, r_seg};

    // fractional part of the angle step carried as a remainder
    assign w_acc     = {1'b0, r_frac} + {1'b0, r_div_rem};
    assign w_wrap    = (w_acc >= {1'b0, r_seg});
    assign w_acc_sub = w_acc - {1'b0, r_seg};
    assign w_last    = (r_vtx == r_seg);

    always_comb begin
        n_state   = r_state;
        n_seg     = r_seg;
        n_cx      = r_cx;
        n_cy      = r_cy;
        n_rx      = r_rx;
        n_ry      = r_ry;
        n_div_rem = r_div_rem;
        n_div_quo = r_div_quo;
        n_div_cnt = r_div_cnt;
        n_angle   = r_angle;
        n_frac    = r_frac;
        n_vtx     = r_vtx;
        unique case (r_state)
            epv_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state   = epv_pkg::ST_DIV;
                    n_seg     = w_eff_seg;
                    n_cx      = i_center_x;
                    n_cy      = i_center_y;
                    n_rx      = i_radius_x;
                    n_ry      = i_radius_y;
                    n_div_rem = '0;
                    n_div_quo = '0;
                    n_div_cnt = DCNT_W'(ADIV_W - 1);
                end
            end
            epv_pkg::ST_DIV: begin
                n_div_rem = w_fits ? w_trial_sub[SEG_W-1:0] : w_trial[SEG_W-1:0];
                n_div_quo = {r_div_quo[ADIV_W-2:0], w_fits};
                n_div_cnt = r_div_cnt - 1'b1;
                if (r_div_cnt == '0) begin
                    n_state = epv_pkg::ST_GEN;
                    n_angle = '0;
                    n_frac  = '0;
                    n_vtx   = '0;
                end
            end
            epv_pkg::ST_GEN: begin
                if (i_advance) begin
                    if (w_last) begin
                        n_state = epv_pkg::ST_IDLE;
                    end else begin
                        n_vtx   = r_vtx + 1'b1;
                        n_frac  = w_wrap ? w_acc_sub[SEG_W-1:0] : w_acc[SEG_W-1:0];
                        n_angle = r_angle + r_div_quo[ANGLE_W-1:0] + ANGLE_W'(w_wrap);
                    end
                end
            end
            default: begin
                n_state = epv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= epv_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seg     <= n_seg;
        r_cx      <= n_cx;
        r_cy      <= n_cy;
        r_rx      <= n_rx;
        r_ry      <= n_ry;
        r_div_rem <= n_div_rem;
        r_div_quo <= n_div_quo;
        r_div_cnt <= n_div_cnt;
        r_angle   <= n_angle;
        r_frac    <= n_frac;
        r_vtx     <= n_vtx;
    end

    always_comb begin
        o_issue.valid    = (r_state == epv_pkg::ST_GEN);
        o_issue.last     = w_last;
        o_issue.angle    = r_angle;
        o_issue.center_x = r_cx;
        o_issue.center_y = r_cy;
        o_issue.radius_x = r_rx;
        o_issue.radius_y = r_ry;
    end

    a_gen_remainders: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == epv_pkg::ST_GEN) |-> (r_frac < r_seg) && (r_div_rem < r_seg))
        else $error("angle step remainder not below segment count");

    a_gen_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == epv_pkg::ST_GEN) |->
            (r_vtx <= r_seg) && (r_seg >= SEG_W'(epv_pkg::MIN_SEGMENTS)))
        else $error("vertex index beyond segment count");

    a_accept_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == epv_pkg::ST_DIV) && (r_div_cnt == DCNT_W'(ADIV_W - 1)))
        else $error("accepted request did not start the division");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_issue.valid && o_issue.last && i_advance) |=> (r_state == epv_pkg::ST_IDLE))
        else $error("closing vertex issued but sequencer still busy");

endmodule

// ===== design/epv_datapath.sv =====
// vertex datapath: quadrant fold, rom lookup, radius multiply, rounding and centre add
// depends on epv_pkg and epv_sine_rom
module epv_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  epv_pkg::t_issue             i_issue,
    output logic                        o_advance,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [epv_pkg::COORD_W-1:0] o_point_x,
    output logic [epv_pkg::COORD_W-1:0] o_point_y,
    output logic                        o_last_point
);

    localparam int ANGLE_W  = epv_pkg::ANGLE_W;
    localparam int ROM_AW   = epv_pkg::ROM_AW;
    localparam int COORD_W  = epv_pkg::COORD_W;
    localparam int RADIUS_W = epv_pkg::RADIUS_W;
    localparam int TRIG_W   = epv_pkg::TRIG_W;
    localparam int PROD_W   = epv_pkg::PROD_W;
    localparam int FRAC_BITS = epv_pkg::FRAC_BITS;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic              neg;
        logic [ROM_AW-1:0] idx;
    } t_fold;

    function automatic t_fold fold_angle(input logic [ANGLE_W-1:0] angle);
        t_fold               f;
        logic [1:0]          quad;
        logic [ANGLE_W-3:0]  offs;
        quad  = angle[ANGLE_W-1:ANGLE_W-2];
        offs  = angle[ANGLE_W-3:0];
        f.neg = quad[1];
        f.idx = quad[0] ? ROM_AW'(epv_pkg::QUARTER_STEPS) - ROM_AW'(offs) : ROM_AW'(offs);
        return f;
    endfunction

    t_fold w_fold_c;
    t_fold w_fold_s;
    logic  w_advance;

    // stage 1: rom read
    logic                r1_valid;
    logic                r1_last;
    logic                r1_neg_c, r1_neg_s;
    logic [COORD_W-1:0]  r1_cx, r1_cy;
    logic [RADIUS_W-1:0] r1_rx, r1_ry;
    logic [TRIG_W-1:0]   w_mag_c, w_mag_s;

    // stage 2: products
    logic                r2_valid;
    logic                r2_last;
    logic                r2_neg_c, r2_neg_s;
    logic [COORD_W-1:0]  r2_cx, r2_cy;
    logic [PROD_W-1:0]   r2_prod_x, r2_prod_y;

    // output stage
    logic                r_out_valid;
    logic                r_out_last;
    logic [COORD_W-1:0]  r_out_x, r_out_y;

    logic [PROD_W-1:0]   w_round_x, w_round_y;
    logic [COORD_W-1:0]  w_off_x, w_off_y;

    // whole pipe moves together whenever the output register can take a beat
    assign w_advance = !r_out_valid || !i_stall;
    assign o_advance = w_advance;

    // cosine is sine a quarter turn on
    assign w_fold_c = fold_angle(i_issue.angle + ANGLE_W'(epv_pkg::QUARTER_STEPS));
    assign w_fold_s = fold_angle(i_issue.angle);

    epv_sine_rom u_rom (
        .i_clk    (i_clk),
        .i_en     (w_advance),
        .i_addr_a (w_fold_c.idx),
        .i_addr_b (w_fold_s.idx),
        .o_data_a (w_mag_c),
        .o_data_b (w_mag_s)
    );

    assign w_round_x = r2_prod_x + ROUND_HALF;
    assign w_round_y = r2_prod_y + ROUND_HALF;
    assign w_off_x   = COORD_W'(w_round_x >> FRAC_BITS);
    assign w_off_y   = COORD_W'(w_round_y >> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r1_valid    <= i_issue.valid;
            r2_valid    <= r1_valid;
            r_out_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r1_last   <= i_issue.last;
            r1_neg_c  <= w_fold_c.neg;
            r1_neg_s  <= w_fold_s.neg;
            r1_cx     <= i_issue.center_x;
            r1_cy     <= i_issue.center_y;
            r1_rx     <= i_issue.radius_x;
            r1_ry     <= i_issue.radius_y;

            r2_last   <= r1_last;
            r2_neg_c  <= r1_neg_c;
            r2_neg_s  <= r1_neg_s;
            r2_cx     <= r1_cx;
            r2_cy     <= r1_cy;
            r2_prod_x <= PROD_W'(r1_rx) * PROD_W'(w_mag_c);
            r2_prod_y <= PROD_W'(r1_ry) * PROD_W'(w_mag_s);

            r_out_last <= r2_last;
            r_out_x    <= r2_neg_c ? r2_cx - w_off_x : r2_cx + w_off_x;
            r_out_y    <= r2_neg_s ? r2_cy - w_off_y : r2_cy + w_off_y;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_point_x    = r_out_x;
    assign o_point_y    = r_out_y;
    assign o_last_point = r_out_last;

    a_cos_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_issue.valid |-> (w_fold_c.idx <= ROM_AW'(epv_pkg::QUARTER_STEPS)))
        else $error("cosine table index out of range");

    a_sin_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_issue.valid |-> (w_fold_s.idx <= ROM_AW'(epv_pkg::QUARTER_STEPS)))
        else $error("sine table index out of range");

endmodule

// ===== design/ellipse_polygon_vertices_core.sv =====
// ellipse polygon vertex generator, top level
// depends on epv_pkg, epv_seq and epv_datapath (which holds epv_sine_rom)
//
// usage
//   request channel (i_valid / o_stall): one beat carries centre, both radii and the
//   segment count; a count below 8 is taken as 32, and the polygon has count + 1 vertices
//   result channel (o_valid / i_stall): one beat per vertex, in order, o_last_point high on
//   the closing vertex, which repeats the first
//   a request is accepted while o_stall is low; o_stall rises the cycle after and stays high
//   until the closing vertex has entered the vertex pipe
// timing
//   setup: restoring division (one quotient bit a cycle) gives the angle step
//   then, while the receiver does not stall, one vertex a cycle enters a 3-stage pipe:
//   table read, multiply, round and add
// reset
//   synchronous, active low; the pipe empties and the sequencer returns to idle
//   the sine table is a constant rom and needs no fill
// stalls
//   when i_stall holds a result, the output register and every pipe stage freeze; the
//   sequencer stops stepping, so no vertex is dropped or repeated
module ellipse_polygon_vertices_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [epv_pkg::COORD_W-1:0]   i_center_x,
    input  logic signed [epv_pkg::COORD_W-1:0]   i_center_y,
    input  logic [epv_pkg::RADIUS_W-1:0]         i_radius_x,
    input  logic [epv_pkg::RADIUS_W-1:0]         i_radius_y,
    input  logic [epv_pkg::SEG_W-1:0]            i_segment_count,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [epv_pkg::COORD_W-1:0]   o_point_x,
    output logic signed [epv_pkg::COORD_W-1:0]   o_point_y,
    output logic                                 o_last_point
);

    // vertex requests from the sequencer into the pipe
    epv_pkg::t_issue w_issue;
    // high when the pipe moves on this cycle
    logic            w_advance;

    logic [epv_pkg::COORD_W-1:0] w_point_x;
    logic [epv_pkg::COORD_W-1:0] w_point_y;

    // holds the request, runs the division and steps the vertex angles
    epv_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_center_x      (i_center_x),
        .i_center_y      (i_center_y),
        .i_radius_x      (i_radius_x),
        .i_radius_y      (i_radius_y),
        .i_segment_count (i_segment_count),
        .i_advance       (w_advance),
        .o_issue         (w_issue)
    );

    // turns each angle into a vertex, coordinates wrap to 16 bits
    epv_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_issue      (w_issue),
        .o_advance    (w_advance),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_point_x    (w_point_x),
        .o_point_y    (w_point_y),
        .o_last_point (o_last_point)
    );

    assign o_point_x = w_point_x;
    assign o_point_y = w_point_y;

endmodule

// ===== bench/epv_vertex_checker.sv =====
// vertex checker for ellipse_polygon_vertices_core: watches both channels, traces the
// expected polygon of each accepted request and compares every vertex beat in order
// depends on epv_pkg for port widths only
module epv_vertex_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_req_valid,
    input  logic                                 i_req_stall,
    input  logic signed [epv_pkg::COORD_W-1:0]   i_center_x,
    input  logic signed [epv_pkg::COORD_W-1:0]   i_center_y,
    input  logic [epv_pkg::RADIUS_W-1:0]         i_radius_x,
    input  logic [epv_pkg::RADIUS_W-1:0]         i_radius_y,
    input  logic [epv_pkg::SEG_W-1:0]            i_segment_count,
    input  logic                                 i_vtx_valid,
    input  logic                                 i_vtx_stall,
    input  logic signed [epv_pkg::COORD_W-1:0]   i_point_x,
    input  logic signed [epv_pkg::COORD_W-1:0]   i_point_y,
    input  logic                                 i_last_point,
    output int                                   o_error_count,
    output int                                   o_vertices_pending
);

    localparam int CIRCLE_STEPS   = 4096;
    localparam int QUADRANT_STEPS = CIRCLE_STEPS / 4;
    localparam int FEWEST_SEGS    = 8;
    localparam int FALLBACK_SEGS  = 32;
    localparam longint unsigned PI_FIXED30  = 64'd3373259426;
    localparam longint unsigned UNIT_FIXED30 = 64'd1 << 30;

    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic        last;
    } t_vertex;

    logic [15:0] sine_quarter [0:QUADRANT_STEPS];
    t_vertex     pending_vertices [$];
    int          vertices_seen;

    // taylor series of sin in q30, rounded to q1.15 and clipped at 1.0
    function automatic logic [15:0] quarter_sine(int k);
        longint unsigned step;
        longint unsigned phase;
        longint unsigned phase_sq;
        longint unsigned term;
        longint unsigned sine30;
        longint unsigned rounded;
        longint unsigned divisors [6];
        divisors = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
        step     = k;
        phase    = (step * 64'd2 * PI_FIXED30) / CIRCLE_STEPS;
        phase_sq = (phase * phase) >> 30;
        term     = UNIT_FIXED30;
        for (int j = 0; j < 6; j++) begin
            term = UNIT_FIXED30 - (((phase_sq * term) >> 30) / divisors[j]);
        end
        sine30  = (phase * term) >> 30;
        rounded = (sine30 + 64'd16384) >> 15;
        if (rounded > 64'd32768) begin
            rounded = 64'd32768;
        end
        return rounded[15:0];
    endfunction

    // centre + round(radius * sin(angle)), halves away from zero, wrapped to 16 bits
    function automatic logic [15:0] vertex_coord(logic [15:0] centre, logic [14:0] radius,
                                                 int unsigned angle);
        int unsigned wrapped;
        int unsigned quadrant;
        int unsigned offset;
        logic [15:0] mag;
        logic [31:0] scaled;
        wrapped  = angle % CIRCLE_STEPS;
        quadrant = wrapped / QUADRANT_STEPS;
        offset   = wrapped % QUADRANT_STEPS;
        mag      = quadrant[0] ? sine_quarter[QUADRANT_STEPS - offset] : sine_quarter[offset];
        scaled   = (32'(radius) * 32'(mag) + 32'd16384) >> 15;
        return (quadrant >= 2) ? centre - scaled[15:0] : centre + scaled[15:0];
    endfunction

    // queue every vertex of the closed polygon, the first one repeated at the end
    task automatic trace_polygon(logic [15:0] cx, logic [15:0] cy, logic [14:0] rx,
                                 logic [14:0] ry, logic [5:0] seg);
        int unsigned segs;
        int unsigned angle;
        t_vertex     v;
        segs = (seg < FEWEST_SEGS) ? FALLBACK_SEGS : seg;
        for (int unsigned i = 0; i <= segs; i++) begin
            angle  = (i * CIRCLE_STEPS) / segs;
            v.x    = vertex_coord(cx, rx, angle + QUADRANT_STEPS);
            v.y    = vertex_coord(cy, ry, angle);
            v.last = (i == segs);
            pending_vertices.push_back(v);
        end
    endtask

    task automatic flag_mismatch(string field, int expected, int actual);
        o_error_count++;
        $display("%0t: vertex %0d %s expected %0d got %0d",
                 $time, vertices_seen, field, expected, actual);
    endtask

    initial begin
        o_error_count      = 0;
        o_vertices_pending = 0;
        vertices_seen      = 0;
        for (int k = 0; k <= QUADRANT_STEPS; k++) begin
            sine_quarter[k] = quarter_sine(k);
        end
    end

    always @(posedge i_clk) begin
        t_vertex want;
        if (i_rst_n) begin
            if (i_vtx_valid && !i_vtx_stall) begin
                if (pending_vertices.size() == 0) begin
                    o_error_count++;
                    $display("%0t: vertex beat with none expected, got x %0d y %0d last %0b",
                             $time, i_point_x, i_point_y, i_last_point);
                end else begin
                    want = pending_vertices.pop_front();
                    if (i_point_x !== want.x) begin
                        flag_mismatch("point_x", $signed(want.x), i_point_x);
                    end
                    if (i_point_y !== want.y) begin
                        flag_mismatch("point_y", $signed(want.y), i_point_y);
                    end
                    if (i_last_point !== want.last) begin
                        flag_mismatch("last_point", want.last, i_last_point);
                    end
                end
                vertices_seen++;
            end
            if (i_req_valid && !i_req_stall) begin
                trace_polygon(i_center_x, i_center_y, i_radius_x, i_radius_y,
                              i_segment_count);
            end
        end
        o_vertices_pending <= pending_vertices.size();
    end

endmodule

// ===== bench/testbench.sv =====
// top of the ellipse polygon bench: clock, reset, request stimulus and receiver stalls
// depends on epv_pkg, ellipse_polygon_vertices_core and epv_vertex_checker
module testbench;

    // worst case: ~320 requests of up to 64 vertices each, held up by stalls, plus gaps and setup
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 300;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RADIUS_MAX    = 32767;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_valid;
    logic                                 o_stall;
    logic signed [epv_pkg::COORD_W-1:0]   i_center_x;
    logic signed [epv_pkg::COORD_W-1:0]   i_center_y;
    logic [epv_pkg::RADIUS_W-1:0]         i_radius_x;
    logic [epv_pkg::RADIUS_W-1:0]         i_radius_y;
    logic [epv_pkg::SEG_W-1:0]            i_segment_count;
    logic                                 o_valid;
    logic                                 i_stall;
    logic signed [epv_pkg::COORD_W-1:0]   o_point_x;
    logic signed [epv_pkg::COORD_W-1:0]   o_point_y;
    logic                                 o_last_point;

    int error_count;
    int vertices_pending;
    int cycle_count;
    int stall_left;
    int calm_left;

    ellipse_polygon_vertices_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_center_x      (i_center_x),
        .i_center_y      (i_center_y),
        .i_radius_x      (i_radius_x),
        .i_radius_y      (i_radius_y),
        .i_segment_count (i_segment_count),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_point_x       (o_point_x),
        .o_point_y       (o_point_y),
        .o_last_point    (o_last_point)
    );

    // watches both channels and checks every vertex beat against its own prediction
    epv_vertex_checker i_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_req_valid        (i_valid),
        .i_req_stall        (o_stall),
        .i_center_x         (i_center_x),
        .i_center_y         (i_center_y),
        .i_radius_x         (i_radius_x),
        .i_radius_y         (i_radius_y),
        .i_segment_count    (i_segment_count),
        .i_vtx_valid        (o_valid),
        .i_vtx_stall        (i_stall),
        .i_point_x          (o_point_x),
        .i_point_y          (o_point_y),
        .i_last_point       (o_last_point),
        .o_error_count      (error_count),
        .o_vertices_pending (vertices_pending)
    );

    always #4 i_clk = ~i_clk;

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver stalls: calm stretches with no stall, otherwise random stall bursts, mostly
    // short, so the stall lands on every phase of the vertex pipe
    always @(negedge i_clk) begin
        if (calm_left > 0) begin
            calm_left--;
            i_stall = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall = 1'b1;
        end else begin
            i_stall = 1'b0;
            case ($urandom_range(0, 15))
                0: begin
                    calm_left = $urandom_range(50, 300);
                end
                1: begin
                    i_stall    = 1'b1;
                    stall_left = $urandom_range(3, 7);
                end
                2, 3, 4: begin
                    i_stall    = 1'b1;
                    stall_left = $urandom_range(0, 1);
                end
                default: begin
                end
            endcase
        end
    end

    // one request beat: payload set at the falling edge and held until accepted
    task automatic send_request(logic signed [15:0] cx, logic signed [15:0] cy,
                                logic [14:0] rx, logic [14:0] ry, logic [5:0] seg);
        @(negedge i_clk);
        i_valid         = 1'b1;
        i_center_x      = cx;
        i_center_y      = cy;
        i_radius_x      = rx;
        i_radius_y      = ry;
        i_segment_count = seg;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
    endtask

    // sender gap: mostly none, sometimes a few cycles, rarely a long one
    task automatic sender_gap();
        int gap;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: gap = 0;
            6, 7, 8:          gap = $urandom_range(1, 3);
            default:          gap = $urandom_range(10, 40);
        endcase
        repeat (gap) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
    endtask

    // hold the request channel quiet until every traced vertex has come back
    task automatic drain_polygons();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (vertices_pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    function automatic logic [14:0] pick_radius();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 15'(RADIUS_MAX);
            2, 3:    return 15'($urandom_range(0, 127));
            default: return 15'($urandom_range(0, RADIUS_MAX));
        endcase
    endfunction

    function automatic logic [5:0] pick_segments();
        case ($urandom_range(0, 7))
            0:       return 6'($urandom_range(0, 7));
            1:       return 6'd63;
            2:       return 6'd8;
            default: return 6'($urandom_range(0, 63));
        endcase
    endfunction

    function automatic logic [15:0] pick_centre();
        case ($urandom_range(0, 7))
            0:       return 16'(16'h7fff - $urandom_range(0, 255));
            1:       return 16'(16'h8000 + $urandom_range(0, 255));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    initial begin
        logic [14:0] rx;
        logic [14:0] ry;
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_stall         = 1'b0;
        i_center_x      = '0;
        i_center_y      = '0;
        i_radius_x      = '0;
        i_radius_y      = '0;
        i_segment_count = '0;
        cycle_count     = 0;
        stall_left      = 0;
        calm_left       = 0;

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: zero radius with count 0 taken as 32
        send_request(16'sd0, 16'sd0, 15'd0, 15'd0, 6'd0);
        // largest circle on the most negative centre, wraps downwards
        send_request(-16'sd32768, -16'sd32768, 15'd32767, 15'd32767, 6'd63);
        sender_gap();
        // largest circle on the most positive centre, wraps upwards, fewest segments
        send_request(16'sd32767, 16'sd32767, 15'd32767, 15'd32767, 6'd8);
        send_request(16'sd100, -16'sd200, 15'd500, 15'd500, 6'd8);
        // small counts all fall back to 32
        send_request(16'sd0, 16'sd0, 15'd1000, 15'd300, 6'd7);
        send_request(16'sd0, 16'sd0, 15'd300, 15'd1000, 6'd1);
        sender_gap();
        // one axis flat: zero radius on y, then on x
        send_request(16'sd1234, -16'sd4321, 15'd32767, 15'd0, 6'd12);
        send_request(-16'sd1, 16'sd1, 15'd0, 15'd32767, 6'd63);
        send_request(16'sd0, 16'sd0, 15'd16384, 15'd16384, 6'd9);
        // unit radii: rounding of the smallest products
        send_request(16'sd32767, -16'sd32768, 15'd1, 15'd1, 6'd63);
        send_request(16'sd0, 16'sd0, 15'd32767, 15'd1, 6'd16);
        send_request(-16'sd5000, 16'sd5000, 15'd20000, 15'd10000, 6'd33);
        send_request(16'sd21845, -16'sd21846, 15'd21845, 15'd10922, 6'd62);

        // sender waits for the whole backlog once before the random part
        drain_polygons();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            rx = pick_radius();
            ry = ($urandom_range(0, 3) == 0) ? rx : pick_radius();
            send_request(pick_centre(), pick_centre(), rx, ry, pick_segments());
            if (n == RANDOM_ITEMS / 2) begin
                drain_polygons();
            end else begin
                sender_gap();
            end
        end

        drain_polygons();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/epv_pkg.sv
design/epv_sine_rom.sv
design/epv_seq.sv
design/epv_datapath.sv
design/ellipse_polygon_vertices_core.sv
bench/epv_vertex_checker.sv
bench/testbench.sv
